@@ rtl/sfe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfe_pkg
// types and constants shared by the softmax fast-exp block
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int unsigned LOGIT_W = 16;
	localparam int unsigned EXP_W   = 17;
	localparam int unsigned SUM_W   = 23;
	localparam int unsigned PROB_W  = 16;
	localparam int unsigned QUO_W   = 33;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [24:0] OFFS_Q24  = 25'd1092111;
	localparam logic [24:0] ONE_Q24   = 25'd16777216;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic                      last_item;
	} in_item_t;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic              last_result;
		logic              too_long;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_EXP_RD,
		ST_EXP_MUL,
		ST_EXP_SH,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // store accepted logit
		logic drop;        // item dropped, set overflow
		logic sum_clr;
		logic exp_mul;     // form u
		logic exp_wr;      // finish exp, write and accumulate
		logic div_start;
		logic div_step;
		logic out_load;
		logic idx_clr;
		logic idx_inc;
		logic vec_clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic store_full;
		logic idx_last;    // index is the final stored element
		logic empty;
		logic div_done;
	} status_t;

endpackage

@@ rtl/sfe_ram.sv @@
// ----------------------------------------------------------------------------
// sfe_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module sfe_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                                rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/sfe_datapath.sv @@
// ----------------------------------------------------------------------------
// sfe_datapath
// stores, max tracking, fast exp, sum and restoring divider
// ----------------------------------------------------------------------------
module sfe_datapath #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfe_pkg::in_item_t   in_item,
	input  sfe_pkg::cmd_t       cmd,
	output sfe_pkg::status_t    status,
	output sfe_pkg::out_item_t  out_item
);
	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        idx_q;
	logic signed [sfe_pkg::LOGIT_W-1:0]   max_q;
	logic [sfe_pkg::SUM_W-1:0]            sum_q;
	logic                                 ovf_q;
	logic [sfe_pkg::LOGIT_W-1:0]          logit_rd;
	logic [sfe_pkg::EXP_W-1:0]            exp_rd;
	logic [sfe_pkg::EXP_W-1:0]            exp_val;
	logic [16:0]                          mag;
	logic [34:0]                          u_q;
	logic [10:0]                          k;
	logic [24:0]                          frac;
	logic [25:0]                          mant;
	logic [11:0]                          sh;
	logic [sfe_pkg::QUO_W-1:0]            rem_q;
	logic [sfe_pkg::QUO_W-1:0]            quo_q;
	logic [5:0]                           bit_q;
	logic [sfe_pkg::QUO_W:0]              trial;
	logic [AW-1:0]                        waddr;
	logic [AW-1:0]                        raddr;

	assign waddr = count_q[AW-1:0];
	assign raddr = idx_q[AW-1:0];

	sfe_ram #(.WIDTH(sfe_pkg::LOGIT_W), .DEPTH(MAX_LEN)) u_logit_ram (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(waddr),
		.wdata(in_item.logit),
		.raddr(raddr),
		.rdata(logit_rd)
	);

	sfe_ram #(.WIDTH(sfe_pkg::EXP_W), .DEPTH(MAX_LEN)) u_exp_ram (
		.clk  (clk),
		.we   (cmd.exp_wr),
		.waddr(raddr),
		.wdata(exp_val),
		.raddr(raddr),
		.rdata(exp_rd)
	);

	// u = (max - x) * log2e + offset, registered
	assign mag = 17'(signed'({max_q[15], max_q}) - signed'({logit_rd[15], logit_rd}));

	// k = ceil(u / 2^24), fraction = k*2^24 - u
	assign k    = 11'((u_q + 35'(sfe_pkg::ONE_Q24 - 25'd1)) >> 24);
	assign frac = 25'(({24'd0, k} << 24) - u_q);
	assign mant = 26'({1'b0, sfe_pkg::ONE_Q24}) + 26'(frac);
	assign sh   = 12'(k) + 12'd8;
	assign exp_val = (sh >= 12'd26) ? '0 : 17'(mant >> sh[4:0]);

	assign trial = {rem_q, quo_q[sfe_pkg::QUO_W-1]} - {11'd0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			max_q   <= 16'sh8000;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			bit_q   <= '0;
		end else begin
			if (cmd.vec_clr) begin
				count_q <= '0;
				max_q   <= 16'sh8000;
				ovf_q   <= 1'b0;
			end
			if (cmd.load) begin
				count_q <= count_q + CW'(1);
				if (in_item.logit > max_q) begin
					max_q <= in_item.logit;
				end
			end
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.sum_clr) begin
				sum_q <= '0;
			end else if (cmd.exp_wr) begin
				sum_q <= sum_q + 23'(exp_val);
			end
			if (cmd.div_start) begin
				bit_q <= 6'(sfe_pkg::QUO_W);
			end else if (cmd.div_step) begin
				bit_q <= bit_q - 6'd1;
			end
		end
	end

	// u register, restoring divide of exp << 16 by sum (one quotient bit a cycle), output load
	always_ff @(posedge clk) begin
		if (cmd.exp_mul) begin
			u_q <= 35'(mag) * 35'(sfe_pkg::LOG2E_Q16) + 35'(sfe_pkg::OFFS_Q24);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {exp_rd, 16'd0};
		end else if (cmd.div_step) begin
			if (!trial[sfe_pkg::QUO_W]) begin
				rem_q <= trial[sfe_pkg::QUO_W-1:0];
				quo_q <= {quo_q[sfe_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[sfe_pkg::QUO_W-2:0], quo_q[sfe_pkg::QUO_W-1]};
				quo_q <= {quo_q[sfe_pkg::QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			if (sum_q == '0) begin
				out_item.probability <= '0;
			end else if (quo_q > 33'd65535) begin
				out_item.probability <= 16'hFFFF;
			end else begin
				out_item.probability <= quo_q[15:0];
			end
			out_item.last_result <= (idx_q + CW'(1) == count_q);
			out_item.too_long    <= ovf_q;
		end
	end

	assign status.store_full = (count_q == CW'(MAX_LEN));
	assign status.idx_last   = (idx_q + CW'(1) == count_q);
	assign status.empty      = (count_q == '0);
	assign status.div_done   = (bit_q == 6'd0);
endmodule

@@ rtl/sfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfe_ctrl
// sequencer for load, exp pass and divide pass
// ----------------------------------------------------------------------------
module sfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sfe_pkg::status_t    status,
	output sfe_pkg::cmd_t       cmd
);
	sfe_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;
	logic            in_fire;

	assign in_ready  = (state_q == sfe_pkg::ST_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfe_pkg::ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			sfe_pkg::ST_LOAD: begin
				if (in_fire) begin
					cmd.load = !status.store_full;
					cmd.drop = status.store_full;
					if (in_last) begin
						cmd.idx_clr = 1'b1;
						cmd.sum_clr = 1'b1;
						state_d     = sfe_pkg::ST_EXP_RD;
					end
				end
			end
			sfe_pkg::ST_EXP_RD: begin
				// ram read in flight
				if (status.empty) begin
					cmd.vec_clr = 1'b1;
					state_d     = sfe_pkg::ST_LOAD;
				end else begin
					state_d = sfe_pkg::ST_EXP_MUL;
				end
			end
			sfe_pkg::ST_EXP_MUL: begin
				cmd.exp_mul = 1'b1;
				state_d     = sfe_pkg::ST_EXP_SH;
			end
			sfe_pkg::ST_EXP_SH: begin
				cmd.exp_wr = 1'b1;
				if (status.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = sfe_pkg::ST_DIV_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = sfe_pkg::ST_EXP_RD;
				end
			end
			sfe_pkg::ST_DIV_RD: begin
				// exp read in flight
				state_d = sfe_pkg::ST_DIV_GO;
			end
			sfe_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = sfe_pkg::ST_DIV_RUN;
			end
			sfe_pkg::ST_DIV_RUN: begin
				if (status.div_done && !out_valid_d) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = sfe_pkg::ST_OUT;
				end else if (!status.div_done) begin
					cmd.div_step = 1'b1;
				end
			end
			sfe_pkg::ST_OUT: begin
				if (status.idx_last) begin
					cmd.vec_clr = 1'b1;
					state_d     = sfe_pkg::ST_LOAD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = sfe_pkg::ST_DIV_RD;
				end
			end
			default: begin
				state_d = sfe_pkg::ST_LOAD;
			end
		endcase
	end
endmodule

@@ rtl/softmax_fast_exp.sv @@
// ----------------------------------------------------------------------------
// softmax_fast_exp
// softmax over a stored vector of q8.8 logits with a bit-trick exponential
// ----------------------------------------------------------------------------
// Logits are taken one per cycle while loading, with the running maximum
// tracked on the fly; items beyond MAX_LEN are dropped and flag too_long on
// every result of the vector. The transfer carrying last_item starts the exp
// pass (per element: ram read, multiply by log2(e), shift) and then the
// divide pass, where each probability goes through ram read, divider start,
// 33 quotient bits at one a cycle, output register load and index step; an
// output stall holds it before the load. Input is held off from the last
// transfer until the final probability is registered.
module softmax_fast_exp #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfe_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sfe_pkg::out_item_t  out_data
);
	sfe_pkg::cmd_t    cmd;
	sfe_pkg::status_t status;

	// sequencer
	sfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_item),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// stores and arithmetic
	sfe_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_data),
		.cmd     (cmd),
		.status  (status),
		.out_item(out_data)
	);
endmodule

@@ test/softmax_fast_exp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_fast_exp_tb
// self-checking bench for the softmax block with the bit-trick exponential
// ----------------------------------------------------------------------------
// Vectors of q8.8 logits are sent over the input channel. A local model of
// the block keeps the current vector, its maximum and the drop flag, and on
// each last_item transfer it queues the expected probabilities. Every output
// transfer is checked against the oldest queued result. A short table of
// directed vectors comes first, then random vectors: mostly short, a few
// near or past the store depth so that items are sometimes dropped.
module softmax_fast_exp_tb;

	localparam int unsigned STORE_DEPTH  = 64;
	localparam int unsigned RANDOM_ITEMS = 345;
	localparam int unsigned HOLD_CYCLES  = 400;

	typedef logic [sfe_pkg::EXP_W-1:0]          exp_t;
	typedef logic [sfe_pkg::SUM_W-1:0]          sum_t;
	typedef logic [sfe_pkg::PROB_W-1:0]         prob_t;
	typedef logic signed [sfe_pkg::LOGIT_W-1:0] logit_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	sfe_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	sfe_pkg::out_item_t out_data;

	// state of the local model for the vector being loaded
	int                 vec_logits[$];
	int                 vec_max;
	logic               vec_dropped;
	sfe_pkg::out_item_t expected_probs[$];

	int unsigned error_count;
	int unsigned result_count;
	int unsigned cycle_count;
	logic        hold_done;

	// directed stimulus: a row may carry a typed probability for a
	// one-element vector, where the answer is plainly saturated
	typedef struct {
		int   logit;
		bit   last;
		bit   typed;
		int   prob;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{32767, 1, 1, 65535},      // single largest logit saturates
		'{-32768, 1, 1, 65535},     // single smallest logit saturates
		'{0, 1, 1, 65535},
		'{32767, 0, 0, 0},          // extremes in one vector
		'{-32768, 1, 0, 0},
		'{-32768, 0, 0, 0},         // max arrives late
		'{32767, 1, 0, 0},
		'{256, 0, 0, 0},            // equal logits share evenly
		'{256, 0, 0, 0},
		'{256, 0, 0, 0},
		'{256, 1, 0, 0},
		'{0, 0, 0, 0},              // one lsb apart in q8.8
		'{1, 1, 0, 0},
		'{512, 0, 0, 0},            // e^-2 and e^-4 steps
		'{0, 0, 0, 0},
		'{-512, 1, 0, 0},
		'{-1, 0, 0, 0},             // all-ones and sign-bit patterns
		'{16'h5555, 0, 0, 0},
		'{-21846, 0, 0, 0},
		'{-16384, 1, 0, 0}
	};

	softmax_fast_exp #(
		.MAX_LEN(STORE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// exp(x - max) in q0.16, via shift and linear mantissa
	function automatic exp_t approx_exp(int x, int mx);
		longint unsigned mag;
		longint unsigned u;
		longint unsigned k;
		longint unsigned f;
		mag = longint'(mx - x);
		u   = mag * 94548 + 1092111;
		k   = (u + 64'd16777215) >> 24;
		f   = (k << 24) - u;
		if (k + 8 >= 26)
			return '0;
		return exp_t'((64'd16777216 + f) >> (k + 8));
	endfunction

	task automatic reset_vector();
		vec_logits.delete();
		vec_max     = -32768;
		vec_dropped = 1'b0;
	endtask

	// accepted item into the model; a last item queues the probabilities
	task automatic absorb_logit(sfe_pkg::in_item_t item, bit typed, int typed_prob);
		exp_t               exps[$];
		sum_t               sum;
		longint unsigned    p;
		sfe_pkg::out_item_t res;
		int                 x;
		x = int'(item.logit);
		if (vec_logits.size() < STORE_DEPTH) begin
			vec_logits = {vec_logits, x};
			if (x > vec_max)
				vec_max = x;
		end else begin
			vec_dropped = 1'b1;
		end
		if (!item.last_item)
			return;
		sum = '0;
		foreach (vec_logits[i]) begin
			exps = {exps, approx_exp(vec_logits[i], vec_max)};
			sum  = sum + sum_t'(exps[i]);
		end
		foreach (exps[i]) begin
			p = 0;
			if (sum != 0) begin
				p = (longint'(exps[i]) << 16) / sum;
				if (p > 65535)
					p = 65535;
			end
			res.probability = typed ? prob_t'(typed_prob) : prob_t'(p);
			res.last_result = (i == exps.size() - 1);
			res.too_long    = vec_dropped;
			expected_probs  = {expected_probs, res};
		end
		reset_vector();
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// one transfer on the input channel, now and then with a random gap before it unless quiet
	task automatic send_logit(int logit, bit last, bit quiet, bit typed, int typed_prob);
		sfe_pkg::in_item_t item;
		logic              ok;
		item.logit     = logit_t'(logit);
		item.last_item = last;
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		absorb_logit(item, typed, typed_prob);
	endtask

	// input side
	initial begin
		int sent;
		int len;
		int base;
		int spread;
		int x;
		bit quiet;
		error_count = 0;
		result_count = 0;
		reset_vector();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send_logit(directed[r].logit, directed[r].last, 1'b0,
				directed[r].typed, directed[r].prob);

		// random vectors: mostly short, now and then near or past the store depth
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len = ($urandom_range(99) < 88) ? $urandom_range(1, 8)
				: $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 6);
			// narrow spreads keep several exps alive, wide ones test the tail
			base   = $urandom_range(65535) - 32768;
			spread = ($urandom_range(1) == 1) ? $urandom_range(3000) : 65535;
			for (int i = 0; i < len; i++) begin
				if (spread == 65535)
					x = int'($urandom_range(65535)) - 32768;
				else begin
					x = base + int'($urandom_range(2 * spread)) - spread;
					if (x > 32767) x = 32767;
					if (x < -32768) x = -32768;
				end
				quiet = (sent >= 150 && sent < 230);
				send_logit(x, i == len - 1, quiet, 1'b0, 0);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (expected_probs.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (expected_probs.size() == 0 && error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// output side: random stalls, a quiet stretch, and one long hold-off
	initial begin
		int unsigned hold_left;
		hold_left   = 0;
		hold_done   = 1'b0;
		cycle_count = 0;
		out_ready   = 1'b0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && result_count >= 30) begin
				// block fills up and must stall its input meanwhile
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (cycle_count >= 4000 && cycle_count < 9000) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 8);
			end
		end
	end

	// output transfers are sampled mid-cycle, ahead of the edge that moves them
	always @(negedge clk) begin
		sfe_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (expected_probs.size() == 0) begin
				report_mismatch($sformatf("unexpected result, probability %0d",
					out_data.probability));
			end else begin
				want = expected_probs.pop_front();
				if (out_data.probability !== want.probability)
					report_mismatch($sformatf("probability %0d, want %0d",
						out_data.probability, want.probability));
				if (out_data.last_result !== want.last_result)
					report_mismatch($sformatf("last_result %b, want %b",
						out_data.last_result, want.last_result));
				if (out_data.too_long !== want.too_long)
					report_mismatch($sformatf("too_long %b, want %b",
						out_data.too_long, want.too_long));
			end
		end
	end

	// watchdog
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
